>>> rtl/core/rcw_pkg.sv
`timescale 1ns / 1ps
package rcw_pkg;

   localparam int CRC_W  = 64;
   localparam int BYTE_W = 8;
   localparam int SIZE_W = 24;

   typedef logic [CRC_W-1:0]  crc_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [SIZE_W-1:0] size_type;

   localparam crc_type  POLY_REFLECTED    = 64'hD800_0000_0000_0000;
   localparam crc_type  CRC_ONE           = 64'h8000_0000_0000_0000;
   localparam size_type WINDOW_SIZE_RESET = 24'd40;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ABSORB = 2'd1;
   localparam logic [1:0] MODE_SLIDE  = 2'd2;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ABSORB = 2'd1;
   localparam logic [1:0] OP_SLIDE  = 2'd2;
   localparam logic [1:0] OP_HOLD   = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      crc_type    crc_load;
      byte_type   byte_new;
      byte_type   byte_old;
   } rcw_item_type;

   typedef struct packed {
      crc_type [BYTE_W-1:0] basis;
      crc_type              mask;
   } rcw_tables_type;

   function automatic crc_type crc_step(crc_type r, byte_type b);
      crc_type a;
      a = {r[BYTE_W-1:0] ^ b, {(CRC_W-BYTE_W){1'b0}}};
      return (r >> BYTE_W) ^ a ^ (a >> 1) ^ (a >> 3) ^ (a >> 4);
   endfunction

   function automatic crc_type basis_seed(logic [2:0] k);
      crc_type r;
      r = {byte_type'(1) << k, {(CRC_W-BYTE_W){1'b0}}};
      return r ^ (r >> 1) ^ (r >> 3) ^ (r >> 4);
   endfunction

   function automatic crc_type table_lookup(crc_type [BYTE_W-1:0] basis, byte_type idx);
      crc_type acc;
      acc = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (idx[k]) begin
            acc = acc ^ basis[k];
         end
      end
      return acc;
   endfunction

endpackage

>>> rtl/core/rcw_front.sv
`timescale 1ns / 1ps
module rcw_front
   import rcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_mode,
   input  crc_type      req_crc_load,
   input  byte_type     req_byte_new,
   input  byte_type     req_byte_old,
   input  logic         busy,
   output logic         q_valid,
   output rcw_item_type q_item,
   input  logic         q_ready
);

   rcw_item_type item_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   rcw_item_type item_in;
   logic         push, pop;

   always_comb begin
      item_in.crc_load = req_crc_load;
      item_in.byte_new = req_byte_new;
      item_in.byte_old = req_byte_old;
      case (req_mode)
         MODE_LOAD:   item_in.op = OP_LOAD;
         MODE_ABSORB: item_in.op = OP_ABSORB;
         MODE_SLIDE:  item_in.op = OP_SLIDE;
         default:     item_in.op = OP_HOLD;
      endcase
   end

   assign req_ready = (count_ff != 2'd2) && !busy;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = item_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/rcw_rebuild.sv
`timescale 1ns / 1ps
module rcw_rebuild
   import rcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  size_type       csr_write_data,
   output logic           busy,
   output rcw_tables_type tables
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_APPLY  = 2'd2;

   localparam logic [5:0] MUL_LAST = 6'(CRC_W - 1);
   localparam logic [4:0] BIT_TOP  = 5'(SIZE_W - 1);
   localparam logic [3:0] VEC_MASK = 4'(BYTE_W);

   logic [1:0]           state_ff, state_in;
   size_type             size_ff, size_in;
   logic [4:0]           bit_ff, bit_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [3:0]           vec_ff, vec_in;
   crc_type              e_ff, e_in;
   crc_type              mul_a_ff, mul_a_in;
   crc_type              mul_b_ff, mul_b_in;
   crc_type              acc_ff, acc_in;
   crc_type [BYTE_W-1:0] basis_ff, basis_in;
   crc_type              mask_ff, mask_in;

   crc_type    acc_step;
   crc_type    e_sq;
   logic [3:0] vec_next;

   function automatic crc_type apply_vec(logic [3:0] v);
      return (v == VEC_MASK) ? '1 : basis_seed(v[2:0]);
   endfunction

   assign acc_step = (acc_ff >> 1) ^ (acc_ff[0] ? POLY_REFLECTED : '0)
                     ^ (mul_b_ff[0] ? mul_a_ff : '0);
   assign e_sq     = size_ff[bit_ff] ? crc_step(acc_step, '0) : acc_step;
   assign vec_next = vec_ff + 4'd1;

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      vec_in   = vec_ff;
      e_in     = e_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      acc_in   = acc_ff;
      basis_in = basis_ff;
      mask_in  = mask_ff;
      if (csr_write_enable) begin
         state_in = ST_SQUARE;
         size_in  = csr_write_data;
         bit_in   = BIT_TOP;
         cnt_in   = '0;
         mul_a_in = CRC_ONE;
         mul_b_in = CRC_ONE;
         acc_in   = '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_SQUARE: begin
               cnt_in   = cnt_ff + 6'd1;
               acc_in   = acc_step;
               mul_b_in = mul_b_ff >> 1;
               if (cnt_ff == MUL_LAST) begin
                  acc_in   = '0;
                  e_in     = e_sq;
                  mul_a_in = e_sq;
                  if (bit_ff == '0) begin
                     state_in = ST_APPLY;
                     vec_in   = '0;
                     mul_b_in = apply_vec('0);
                  end else begin
                     bit_in   = bit_ff - 5'd1;
                     mul_b_in = e_sq;
                  end
               end
            end
            ST_APPLY: begin
               cnt_in   = cnt_ff + 6'd1;
               acc_in   = acc_step;
               mul_b_in = mul_b_ff >> 1;
               if (cnt_ff == MUL_LAST) begin
                  acc_in = '0;
                  if (vec_ff == VEC_MASK) begin
                     mask_in  = acc_step ^ '1;
                     state_in = ST_IDLE;
                  end else begin
                     basis_in[vec_ff[2:0]] = acc_step;
                     vec_in                = vec_next;
                     mul_a_in              = e_ff;
                     mul_b_in              = apply_vec(vec_next);
                  end
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SQUARE;
         size_ff  <= WINDOW_SIZE_RESET;
         bit_ff   <= BIT_TOP;
         cnt_ff   <= '0;
         mul_a_ff <= CRC_ONE;
         mul_b_ff <= CRC_ONE;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         bit_ff   <= bit_in;
         cnt_ff   <= cnt_in;
         mul_a_ff <= mul_a_in;
         mul_b_ff <= mul_b_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff   <= vec_in;
      e_ff     <= e_in;
      basis_ff <= basis_in;
      mask_ff  <= mask_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign tables.basis = basis_ff;
   assign tables.mask  = mask_ff;

endmodule

>>> rtl/core/rcw_back.sv
`timescale 1ns / 1ps
module rcw_back
   import rcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  rcw_item_type   q_item,
   output logic           q_ready,
   input  rcw_tables_type tables,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output crc_type        rsp_crc_out
);

   crc_type crc_ff, crc_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    take;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign take    = q_valid && q_ready;

   always_comb begin
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         rsp_valid_in = 1'b1;
         case (q_item.op)
            OP_LOAD:   crc_in = q_item.crc_load;
            OP_ABSORB: crc_in = ~crc_step(~crc_ff, q_item.byte_new);
            OP_SLIDE:  crc_in = tables.mask
                                ^ crc_step(tables.mask ^ crc_ff, q_item.byte_new)
                                ^ table_lookup(tables.basis, q_item.byte_old);
            default:   crc_in = crc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_crc_out = crc_ff;

endmodule

>>> rtl/core/rolling_crc64_window_core.sv
// A request passes a two-entry queue, then one output register that presents its response.
// Throughput: one item per cycle unless a table rebuild or rsp_ready low holds the flow.
// Reset and every csr write start a table rebuild (24 squaring and 9 product passes of
// a bit-serial GF(2) multiplier); req_ready is low meanwhile.
// Reset is synchronous, active high; it clears the CRC and loads a window size of 40.
`timescale 1ns / 1ps
module rolling_crc64_window_core
   import rcw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [1:0] req_mode,
   input  crc_type  req_crc_load,
   input  byte_type req_byte_new,
   input  byte_type req_byte_old,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output crc_type  rsp_crc_out,
   input  logic     csr_write_enable,
   input  size_type csr_write_data
);

   logic           busy;
   logic           q_valid;
   logic           q_ready;
   rcw_item_type   q_item;
   rcw_tables_type tables;

   rcw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_crc_load (req_crc_load),
      .req_byte_new (req_byte_new),
      .req_byte_old (req_byte_old),
      .busy         (busy),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_ready      (q_ready)
   );

   rcw_rebuild u_rebuild (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .busy             (busy),
      .tables           (tables)
   );

   rcw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_ready     (q_ready),
      .tables      (tables),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_crc_out (rsp_crc_out)
   );

endmodule

>>> rtl/core/rcw_checker.sv
`timescale 1ns / 1ps
module rcw_checker
   import rcw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input crc_type rsp_crc_out,
   input logic    csr_write_enable
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("outputs active right after reset");

   a_rebuild_blocks: assert property (@(posedge clock)
      csr_write_enable |=> !req_ready)
      else $error("request taken during table rebuild");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no response after request transfer");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crc_out))
      else $error("stalled response changed");

endmodule

bind rolling_crc64_window_core rcw_checker u_checker (.*);
